### hdl/bmark_pkg.sv
// shared types and constants for the bookmark set with wrap search
package bmark_pkg;

  localparam int unsigned MaxMarksDef = 32;
  localparam int unsigned AddrW       = 32;

  typedef enum logic [1:0] {
    CMD_TOGGLE = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

### hdl/bookmark_set_with_wrap_search_core.sv
// bookmark set with toggle, check and wrap-around next search
//
//  channel   handshake          payload
//  command   start / busy       command_i, address_i, doc_length_i
//  result    done_o (strobe)    is_marked_o, found_o, next_address_o, table_full_o
//
// one compare unit walks the mark memory one entry per cycle (read data registered)
// check and toggle walk every entry once; next walks every entry, and again from zero on wrap
// unused command: no scan; busy is high from the accepting edge to the result
// reset clears every valid bit at once, the address memory needs no clearing
// the result strobe lasts one cycle and cannot be held off by the receiver
module bookmark_set_with_wrap_search_core #(
  parameter int unsigned MaxMarks = bmark_pkg::MaxMarksDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command_i,
  input  logic [bmark_pkg::AddrW-1:0] address_i,
  input  logic [bmark_pkg::AddrW-1:0] doc_length_i,
  output logic                        done_o,
  output logic                        is_marked_o,
  output logic                        found_o,
  output logic [bmark_pkg::AddrW-1:0] next_address_o,
  output logic                        table_full_o
);

  localparam int unsigned IdxW = (MaxMarks > 1) ? $clog2(MaxMarks) : 1;
  localparam int unsigned CntW = $clog2(MaxMarks + 1);
  localparam int unsigned AW   = bmark_pkg::AddrW;

  bmark_pkg::state_e state_q, state_d;
  bmark_pkg::cmd_e   cmd_q, cmd_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     len_q, len_d;
  logic [AW-1:0]     best_q, best_d;
  logic              wrap_q, wrap_d;
  logic              matched_q, matched_d;
  logic              free_found_q, free_found_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;
  logic [CntW-1:0]   iss_cnt_q, iss_cnt_d;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [AW-1:0]     rd_data_q;
  logic [MaxMarks-1:0] valid_q, valid_d;

  logic              done_d, is_marked_d, found_d, table_full_d;
  logic [AW-1:0]     next_address_d;
  logic              issue;
  logic              mem_we;
  logic [AW-1:0]     lo;
  logic              entry_vld, entry_eq, entry_stale;

  logic [AW-1:0] mark_mem [MaxMarks];

  assign busy      = (state_q != bmark_pkg::ST_IDLE);
  assign issue     = (state_q == bmark_pkg::ST_SCAN) && (iss_cnt_q < CntW'(MaxMarks));
  assign lo        = wrap_q ? '0 : addr_q;
  assign entry_vld   = valid_q[rd_idx_q];
  assign entry_eq    = (rd_data_q == addr_q);
  assign entry_stale = (rd_data_q >= len_q);

  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    addr_d         = addr_q;
    len_d          = len_q;
    best_d         = best_q;
    wrap_d         = wrap_q;
    matched_d      = matched_q;
    free_found_d   = free_found_q;
    free_idx_d     = free_idx_q;
    iss_cnt_d      = iss_cnt_q;
    valid_d        = valid_q;
    mem_we         = 1'b0;
    done_d         = 1'b0;
    is_marked_d    = is_marked_o;
    found_d        = found_o;
    next_address_d = next_address_o;
    table_full_d   = table_full_o;

    if (issue) begin
      iss_cnt_d = iss_cnt_q + CntW'(1);
    end

    // one entry per cycle through the shared compare
    if (rd_vld_q) begin
      case (cmd_q)
        bmark_pkg::CMD_TOGGLE: begin
          if (entry_vld && (entry_eq || entry_stale)) begin
            valid_d[rd_idx_q] = 1'b0;
          end
          if (entry_vld && entry_eq) begin
            matched_d = 1'b1;
          end
          if (!free_found_q && (!entry_vld || entry_eq || entry_stale)) begin
            free_found_d = 1'b1;
            free_idx_d   = rd_idx_q;
          end
        end
        bmark_pkg::CMD_CHECK: begin
          if (entry_vld && entry_eq) begin
            matched_d = 1'b1;
          end
        end
        bmark_pkg::CMD_NEXT: begin
          if (entry_vld && (rd_data_q > lo) && (rd_data_q < best_q)) begin
            best_d = rd_data_q;
          end
        end
        default: ;
      endcase
    end

    unique case (state_q)
      bmark_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d        = bmark_pkg::cmd_e'(command_i);
          addr_d       = address_i;
          len_d        = doc_length_i;
          best_d       = doc_length_i;
          wrap_d       = 1'b0;
          matched_d    = 1'b0;
          free_found_d = 1'b0;
          free_idx_d   = '0;
          iss_cnt_d    = '0;
          state_d      = (bmark_pkg::cmd_e'(command_i) == bmark_pkg::CMD_NONE) ?
                         bmark_pkg::ST_DONE : bmark_pkg::ST_SCAN;
        end
      end
      bmark_pkg::ST_SCAN: begin
        if (!issue && !rd_vld_q) begin
          if (cmd_q == bmark_pkg::CMD_NEXT && !wrap_q && best_q == len_q && addr_q != '0) begin
            // nothing above the start: search again from zero
            wrap_d    = 1'b1;
            iss_cnt_d = '0;
          end else begin
            state_d = bmark_pkg::ST_DONE;
          end
        end
      end
      bmark_pkg::ST_DONE: begin
        state_d        = bmark_pkg::ST_IDLE;
        done_d         = 1'b1;
        is_marked_d    = 1'b0;
        found_d        = 1'b0;
        next_address_d = '0;
        table_full_d   = 1'b0;
        case (cmd_q)
          bmark_pkg::CMD_TOGGLE: begin
            if (!matched_q) begin
              if (free_found_q) begin
                mem_we              = 1'b1;
                valid_d[free_idx_q] = 1'b1;
                is_marked_d         = 1'b1;
              end else begin
                table_full_d = 1'b1;
              end
            end
          end
          bmark_pkg::CMD_CHECK: begin
            is_marked_d = matched_q;
          end
          bmark_pkg::CMD_NEXT: begin
            if (best_q < len_q) begin
              found_d        = 1'b1;
              next_address_d = best_q;
            end
          end
          default: ;
        endcase
      end
      default: state_d = bmark_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bmark_pkg::ST_IDLE;
      cmd_q          <= bmark_pkg::CMD_NONE;
      wrap_q         <= 1'b0;
      matched_q      <= 1'b0;
      free_found_q   <= 1'b0;
      iss_cnt_q      <= '0;
      rd_vld_q       <= 1'b0;
      valid_q        <= '0;
      done_o         <= 1'b0;
      is_marked_o    <= 1'b0;
      found_o        <= 1'b0;
      next_address_o <= '0;
      table_full_o   <= 1'b0;
    end else begin
      state_q        <= state_d;
      cmd_q          <= cmd_d;
      wrap_q         <= wrap_d;
      matched_q      <= matched_d;
      free_found_q   <= free_found_d;
      iss_cnt_q      <= iss_cnt_d;
      rd_vld_q       <= issue;
      valid_q        <= valid_d;
      done_o         <= done_d;
      is_marked_o    <= is_marked_d;
      found_o        <= found_d;
      next_address_o <= next_address_d;
      table_full_o   <= table_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    len_q      <= len_d;
    best_q     <= best_d;
    free_idx_q <= free_idx_d;
    rd_idx_q   <= iss_cnt_q[IdxW-1:0];
  end

  // mark address memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mark_mem[free_idx_q] <= addr_q;
    end
    rd_data_q <= mark_mem[iss_cnt_q[IdxW-1:0]];
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  a_found_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> next_address_o < len_q && next_address_o != '0)
    else $error("next mark outside the search range");

  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && table_full_o |-> !is_marked_o && (&valid_q))
    else $error("table full reported with a free slot");

  a_scan_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bmark_pkg::ST_SCAN |=> !done_o)
    else $error("result strobe during a scan");

endmodule

### verif/bookmark_set_with_wrap_search_core_tb.sv
// self-checking testbench for the bookmark set with wrap-around search core
`timescale 1ns / 100ps

module bookmark_set_with_wrap_search_core_tb;

  localparam int unsigned NumMarks  = bmark_pkg::MaxMarksDef;
  localparam logic [31:0] LenMax    = 32'hFFFF_FFF0;
  localparam int unsigned RandItems = 1650;
  localparam int unsigned PhaseLen  = 550;
  localparam int unsigned WdLimit   = 4000;
  localparam int unsigned TailWait  = 80;

  typedef struct {
    bmark_pkg::cmd_e cmd;
    logic [31:0] addr;
    logic [31:0] len;
    int unsigned idle_pct;
    bit          drain_first;
  } mark_cmd_t;

  typedef struct {
    logic        is_marked;
    logic        found;
    logic [31:0] next_address;
    logic        table_full;
  } mark_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  bmark_pkg::cmd_e command_i = bmark_pkg::CMD_TOGGLE;
  logic [31:0] address_i = '0;
  logic [31:0] doc_length_i = '0;
  logic        done_o;
  logic        is_marked_o;
  logic        found_o;
  logic [31:0] next_address_o;
  logic        table_full_o;

  // predicted mark table
  logic [31:0] mark_at [NumMarks];
  bit          mark_live [NumMarks];

  mark_cmd_t    cmd_queue [$];
  mark_result_t expected_results [$];
  int           n_sent = 0;
  int           n_recv = 0;
  int           n_errors = 0;
  int unsigned  idle_cycles = 0;
  bit           wd_expired = 1'b0;

  // stimulus build state
  int unsigned  cur_idle = 0;
  bit           drain_next = 1'b0;
  int unsigned  n_queued = 0;
  logic [31:0]  addr_pool [64];

  bookmark_set_with_wrap_search_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .address_i      (address_i),
    .doc_length_i   (doc_length_i),
    .done_o         (done_o),
    .is_marked_o    (is_marked_o),
    .found_o        (found_o),
    .next_address_o (next_address_o),
    .table_full_o   (table_full_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // smallest live mark strictly between lo and hi, hi when there is none
  function automatic logic [31:0] lowest_mark_above(logic [31:0] lo, logic [31:0] hi);
    logic [31:0] best;
    best = hi;
    for (int i = 0; i < NumMarks; i++) begin
      if (mark_live[i] && mark_at[i] > lo && mark_at[i] < best) best = mark_at[i];
    end
    return best;
  endfunction

  function automatic mark_result_t bookmark_apply(bmark_pkg::cmd_e cmd, logic [31:0] addr,
                                                  logic [31:0] len);
    mark_result_t res;
    bit hit;
    int slot;
    logic [31:0] best;
    res = '{is_marked: 1'b0, found: 1'b0, next_address: '0, table_full: 1'b0};
    hit = 1'b0;
    slot = -1;
    case (cmd)
      bmark_pkg::CMD_TOGGLE: begin
        // removal of a match and pruning of stale marks in one pass
        for (int i = 0; i < NumMarks; i++) begin
          if (mark_live[i]) begin
            if (mark_at[i] == addr) begin
              hit = 1'b1;
              mark_live[i] = 1'b0;
            end else if (mark_at[i] >= len) begin
              mark_live[i] = 1'b0;
            end
          end
        end
        if (!hit) begin
          for (int i = 0; i < NumMarks; i++) begin
            if (!mark_live[i] && slot < 0) slot = i;
          end
          if (slot >= 0) begin
            mark_at[slot] = addr;
            mark_live[slot] = 1'b1;
            res.is_marked = 1'b1;
          end else begin
            res.table_full = 1'b1;
          end
        end
      end
      bmark_pkg::CMD_CHECK: begin
        for (int i = 0; i < NumMarks; i++) begin
          if (mark_live[i] && mark_at[i] == addr) res.is_marked = 1'b1;
        end
      end
      bmark_pkg::CMD_NEXT: begin
        best = lowest_mark_above(addr, len);
        if (best == len && addr != '0) best = lowest_mark_above('0, len);
        if (best < len) begin
          res.found = 1'b1;
          res.next_address = best;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_cmd(bmark_pkg::cmd_e cmd, logic [31:0] addr, logic [31:0] len);
    mark_cmd_t c;
    c.cmd = cmd;
    c.addr = addr;
    c.len = len;
    c.idle_pct = cur_idle;
    c.drain_first = drain_next || ($urandom_range(99) == 0);
    drain_next = 1'b0;
    cmd_queue.push_back(c);
    if (cmd != bmark_pkg::CMD_NONE) n_queued++;
  endtask

  function automatic logic [31:0] rand_len();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(99);
    if (r < 80) begin
      v = $urandom_range(LenMax, LenMax - 15);
    end else if (r < 88) begin
      v = addr_pool[$urandom_range(63)];
      if (v > LenMax) v = LenMax;
    end else if (r < 92) begin
      v = '0;
    end else begin
      v = $urandom_range(LenMax, 0);
    end
    return v;
  endfunction

  task automatic queue_mixed(int unsigned window, int unsigned count);
    int unsigned r;
    logic [31:0] a;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 45 || r >= 95) begin
        a = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(window - 1)] : $urandom;
        queue_cmd((r < 45) ? bmark_pkg::CMD_TOGGLE : bmark_pkg::CMD_NONE, a, rand_len());
      end else if (r < 65) begin
        a = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(window - 1)] : $urandom;
        queue_cmd(bmark_pkg::CMD_CHECK, a, rand_len());
      end else begin
        r = $urandom_range(99);
        a = (r < 50) ? addr_pool[$urandom_range(window - 1)] : (r < 65) ? 32'd0 : $urandom;
        queue_cmd(bmark_pkg::CMD_NEXT, a, rand_len());
      end
    end
  endtask

  task automatic build_stimulus();
    logic [31:0] fresh [$];
    logic [31:0] base;
    logic [31:0] a;
    int unsigned kind;
    int unsigned n_fill;
    int unsigned phase;
    int unsigned last_phase;
    int unsigned windows [3];

    addr_pool[0] = 32'd0;
    addr_pool[1] = 32'd1;
    addr_pool[2] = 32'hFFFF_FFFF;
    addr_pool[3] = LenMax;
    base = '0;
    for (int i = 4; i < 64; i++) begin
      // clusters of near neighbors so searches land between marks
      if (i % 4 == 0) base = $urandom;
      addr_pool[i] = base + (i % 4) * $urandom_range(3, 1);
    end
    windows = '{8, 24, 64};

    // directed part, no idling
    queue_cmd(bmark_pkg::CMD_CHECK, 32'd0, LenMax);
    queue_cmd(bmark_pkg::CMD_NEXT, 32'd0, LenMax);
    queue_cmd(bmark_pkg::CMD_TOGGLE, 32'd0, LenMax);
    queue_cmd(bmark_pkg::CMD_NEXT, 32'd0, LenMax);        // mark at zero never returned
    queue_cmd(bmark_pkg::CMD_NEXT, 32'd5, LenMax);        // wrap finds nothing either
    queue_cmd(bmark_pkg::CMD_TOGGLE, 32'd100, LenMax);
    queue_cmd(bmark_pkg::CMD_TOGGLE, 32'd300, LenMax);
    queue_cmd(bmark_pkg::CMD_NEXT, 32'd100, LenMax);
    queue_cmd(bmark_pkg::CMD_NEXT, 32'd300, LenMax);      // wraps back to 100
    queue_cmd(bmark_pkg::CMD_NEXT, 32'd0, 32'd200);
    queue_cmd(bmark_pkg::CMD_NEXT, 32'd150, 32'd200);     // 300 beyond length, wraps
    queue_cmd(bmark_pkg::CMD_NEXT, 32'd50, 32'd0);        // zero length finds nothing
    queue_cmd(bmark_pkg::CMD_NEXT, 32'hFFFF_FFFF, LenMax);
    queue_cmd(bmark_pkg::CMD_TOGGLE, 32'hFFFF_FFFF, LenMax); // added although stale
    queue_cmd(bmark_pkg::CMD_CHECK, 32'hFFFF_FFFF, LenMax);  // stale mark still reported
    queue_cmd(bmark_pkg::CMD_TOGGLE, 32'd100, LenMax);  // removes 100, prunes the stale one
    queue_cmd(bmark_pkg::CMD_CHECK, 32'hFFFF_FFFF, LenMax);
    queue_cmd(bmark_pkg::CMD_CHECK, 32'd300, 32'd0);
    queue_cmd(bmark_pkg::CMD_NONE, 32'hFFFF_FFFF, LenMax);
    queue_cmd(bmark_pkg::CMD_TOGGLE, 32'd0, 32'd1);
    queue_cmd(bmark_pkg::CMD_TOGGLE, 32'h5555_AAAA, 32'd0);  // prunes everything then adds
    queue_cmd(bmark_pkg::CMD_NEXT, 32'd1, 32'hAAAA_5555);
    queue_cmd(bmark_pkg::CMD_CHECK, 32'h5555_AAAA, 32'd7);

    n_queued = 0;
    last_phase = 99;
    while (n_queued < RandItems) begin
      phase = n_queued / PhaseLen;
      if (phase != last_phase) begin
        cur_idle = (phase == 0) ? 0 : (phase == 1) ? 82 : 32;
        drain_next = 1'b1;
        last_phase = phase;
      end
      kind = $urandom_range(9);
      if (kind < 2) begin
        // fill the table with fresh addresses, which can make it overflow
        n_fill = $urandom_range(40, 30);
        for (int k = 0; k < n_fill; k++) begin
          a = $urandom;
          fresh.push_back(a);
          queue_cmd(bmark_pkg::CMD_TOGGLE, a, LenMax);
          if ($urandom_range(3) == 0) queue_cmd(bmark_pkg::CMD_NEXT, $urandom, LenMax);
          if ($urandom_range(5) == 0) queue_cmd(bmark_pkg::CMD_CHECK, a, LenMax);
        end
      end else if (kind == 2) begin
        while (fresh.size() > 0) queue_cmd(bmark_pkg::CMD_TOGGLE, fresh.pop_front(), LenMax);
      end else begin
        queue_mixed(windows[$urandom_range(2)], 40);
      end
    end
  endtask

  // driver: one transfer per accepted command
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      n_sent <= 0;
    end else begin : drive_b
      bit accept_now;
      int outstanding;
      mark_cmd_t c;
      accept_now = start && !busy;
      if (accept_now) begin
        expected_results.push_back(bookmark_apply(command_i, address_i, doc_length_i));
        n_sent <= n_sent + 1;
      end
      outstanding = n_sent + int'(accept_now) - n_recv - int'(done_o);
      if (start && busy) begin
        // hold the current command
      end else if (cmd_queue.size() > 0 && (!cmd_queue[0].drain_first || outstanding == 0)
                   && $urandom_range(99) >= cmd_queue[0].idle_pct) begin
        c = cmd_queue.pop_front();
        start <= 1'b1;
        command_i <= c.cmd;
        address_i <= c.addr;
        doc_length_i <= c.len;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin : check_b
      mark_result_t want;
      n_recv <= n_recv + 1;
      if (n_recv >= n_sent) begin
        $error("result transfer with no command outstanding");
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (is_marked_o !== want.is_marked) begin
          $error("is_marked: expected %0d, got %0d", want.is_marked, is_marked_o);
          n_errors++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          n_errors++;
        end
        if (next_address_o !== want.next_address) begin
          $error("next_address: expected %h, got %h", want.next_address, next_address_o);
          n_errors++;
        end
        if (table_full_o !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, table_full_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WdLimit) begin
        wd_expired <= 1'b1;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < NumMarks; i++) begin
      mark_at[i] = '0;
      mark_live[i] = 1'b0;
    end
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (!wd_expired && !(cmd_queue.size() == 0 && !start && n_sent == n_recv)) begin
      @(negedge clk_i);
    end
    if (wd_expired) begin
      $display("FAILURE");
    end else begin
      repeat (TailWait) @(posedge clk_i);
      if (n_errors == 0 && expected_results.size() == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

endmodule
